[rtl/imgconv_pkg.sv]
// ----------------------------------------------------------------------------
// imgconv_pkg
// Shared types, widths and codes of the 2d convolution image filter.
// ----------------------------------------------------------------------------
`default_nettype none

package imgconv_pkg;

  localparam int MAX_PIXELS_DEF      = 4096;
  localparam int MAX_KERNEL_TAPS_DEF = 49;

  localparam int DATA_W     = 16;  // pixel, weight and result width
  localparam int SLOT_W     = 12;
  localparam int POS_W      = 6;   // column and row
  localparam int DIM_W      = 7;   // image width and height
  localparam int KDIM_W     = 3;   // kernel width and height
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int ADDR_W     = 16;  // signed tap address
  localparam int TAP_W      = 6;   // weight index, up to 7*7-1

  typedef logic        [OP_W-1:0]      opcode_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_index_t;
  typedef logic signed [DATA_W-1:0]    sample_t;

  localparam opcode_t OP_WRITE_PIXEL  = 2'd0;
  localparam opcode_t OP_WRITE_WEIGHT = 2'd1;
  localparam opcode_t OP_COMPUTE      = 2'd2;

  localparam cfg_index_t CFG_IMAGE_WIDTH   = 2'd0;
  localparam cfg_index_t CFG_IMAGE_HEIGHT  = 2'd1;
  localparam cfg_index_t CFG_KERNEL_WIDTH  = 2'd2;
  localparam cfg_index_t CFG_KERNEL_HEIGHT = 2'd3;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic clear;  // start of a new window sum
    logic valid;  // pixel and weight data of one tap are present
    logic zero;   // tap falls outside the image or the weight store
  } tap_ctl_t;

endpackage

`default_nettype wire

[rtl/imgconv_mac.sv]
// ----------------------------------------------------------------------------
// imgconv_mac
// Shared multiply-accumulate unit: one tap product per cycle, registered,
// then added into a 16-bit wrapping accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module imgconv_mac (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire imgconv_pkg::tap_ctl_t  ctl,
  input  wire imgconv_pkg::sample_t   pixel,
  input  wire imgconv_pkg::sample_t   weight,
  output imgconv_pkg::sample_t        acc,
  output logic                        busy
);
  import imgconv_pkg::*;

  logic signed [2*DATA_W-1:0] prod_full;
  sample_t                    prod_r;
  logic                       prod_vld_r;
  sample_t                    acc_r;

  assign prod_full = pixel * weight;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.valid;
    end
  end

  // only the low half of the product matters, the sum wraps to 16 bits
  always_ff @(posedge clk) begin
    prod_r <= ctl.zero ? '0 : sample_t'(prod_full[DATA_W-1:0]);
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign acc  = acc_r;
  assign busy = prod_vld_r;

endmodule

`default_nettype wire

[rtl/image_conv2d_filter.sv]
// ----------------------------------------------------------------------------
// image_conv2d_filter
// 2d convolution over a stored image of signed 16-bit pixels.
// ----------------------------------------------------------------------------
// Input words carry an opcode: write pixel (slot is the linear address),
// write kernel weight (slot is ky*kernel_width+kx) or compute the filtered
// pixel at column/row. Only compute words give a result word.
// Configuration (image and kernel sizes) is written through cfg_we/cfg_index/
// cfg_data; the user must do so while the block is idle, which is not enforced.
// Write words never raise in_stall. A compute word passes an address setup
// state, then, unless a kernel size is zero, a run state with one tap per cycle
// through the shared multiply-accumulate unit (kernel_width*kernel_height taps),
// then a drain state while its read, product and sum stages empty. The result
// enters the output register when the drain ends, once that register is free.
// in_stall is high while a compute word is in progress. When the receiver
// stalls, the result is held in the output register; write words are still
// taken meanwhile, a following compute word waits at its end for the
// register to free up. After reset the sizes are 64x64 image, 3x3 kernel;
// stores are undefined until written and need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module image_conv2d_filter #(
  parameter int MAX_PIXELS      = imgconv_pkg::MAX_PIXELS_DEF,
  parameter int MAX_KERNEL_TAPS = imgconv_pkg::MAX_KERNEL_TAPS_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  // input channel
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire imgconv_pkg::opcode_t              in_opcode,
  input  wire [imgconv_pkg::SLOT_W-1:0]          in_slot,
  input  wire imgconv_pkg::sample_t              in_sample_value,
  input  wire [imgconv_pkg::POS_W-1:0]           in_column,
  input  wire [imgconv_pkg::POS_W-1:0]           in_row,
  // result channel
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output imgconv_pkg::sample_t                   out_filtered_value,
  // configuration
  input  wire                                    cfg_we,
  input  wire imgconv_pkg::cfg_index_t           cfg_index,
  input  wire [imgconv_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import imgconv_pkg::*;

  localparam int PIX_AW = $clog2(MAX_PIXELS);
  localparam int WGT_AW = (MAX_KERNEL_TAPS > 1) ? $clog2(MAX_KERNEL_TAPS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  // stores
  sample_t image_mem  [MAX_PIXELS];
  sample_t weight_mem [MAX_KERNEL_TAPS];

  // configuration
  logic [DIM_W-1:0]  img_width_r, img_height_r;
  logic [KDIM_W-1:0] krn_width_r, krn_height_r;

  // sequencer
  logic [1:0]               state_r, state_nxt;
  logic [POS_W-1:0]         col_r, row_r;
  logic [2*DIM_W-1:0]       size_r, size_nxt;
  logic signed [ADDR_W-1:0] row_addr_r, addr_r, start_addr, width_a;
  logic [KDIM_W-1:0]        kx_r, ky_r;
  logic [TAP_W-1:0]         widx_r;
  logic                     tap_vld_r, tap_zero_r;
  sample_t                  pix_q_r, wgt_q_r;
  logic                     out_valid_r;
  sample_t                  out_value_r;

  logic                     in_acc, compute_acc, tap_issue, last_kx, last_ky;
  logic                     pix_slot_ok, wgt_slot_ok, pix_ok, wgt_ok;
  logic                     pipe_busy, out_free, out_load, no_taps;
  logic [KDIM_W-1:0]        half_kw, half_kh;
  logic signed [7:0]        base_row, width_s;
  logic signed [ADDR_W-1:0] row_prod;
  logic [ADDR_W-1:0]        addr_u;
  logic [PIX_AW-1:0]        pix_waddr, pix_raddr;
  logic [WGT_AW-1:0]        wgt_waddr, wgt_raddr;

  tap_ctl_t                 mac_ctl;
  sample_t                  mac_acc;
  logic                     mac_busy;

  assign in_stall    = (state_r != ST_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign compute_acc = in_acc && (in_opcode == OP_COMPUTE);

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= DIM_W'(64);
      img_height_r <= DIM_W'(64);
      krn_width_r  <= KDIM_W'(3);
      krn_height_r <= KDIM_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:   img_width_r  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  img_height_r <= cfg_data[DIM_W-1:0];
        CFG_KERNEL_WIDTH:  krn_width_r  <= cfg_data[KDIM_W-1:0];
        CFG_KERNEL_HEIGHT: krn_height_r <= cfg_data[KDIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- store writes and tap reads ----------------
  assign pix_slot_ok = 32'(in_slot) < MAX_PIXELS;
  assign wgt_slot_ok = 32'(in_slot) < MAX_KERNEL_TAPS;
  assign pix_waddr   = PIX_AW'(in_slot);
  assign wgt_waddr   = WGT_AW'(in_slot);

  assign addr_u    = unsigned'(addr_r);
  assign pix_ok    = !addr_r[ADDR_W-1] && (addr_u < ADDR_W'(size_r))
                     && (32'(addr_u) < MAX_PIXELS);
  assign wgt_ok    = 32'(widx_r) < MAX_KERNEL_TAPS;
  assign pix_raddr = PIX_AW'(addr_u);
  assign wgt_raddr = WGT_AW'(widx_r);
  assign tap_issue = (state_r == ST_RUN);

  always_ff @(posedge clk) begin
    if (in_acc && (in_opcode == OP_WRITE_PIXEL) && pix_slot_ok) begin
      image_mem[pix_waddr] <= in_sample_value;
    end
    if (tap_issue && pix_ok) begin
      pix_q_r <= image_mem[pix_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_opcode == OP_WRITE_WEIGHT) && wgt_slot_ok) begin
      weight_mem[wgt_waddr] <= in_sample_value;
    end
    if (tap_issue && wgt_ok) begin
      wgt_q_r <= weight_mem[wgt_raddr];
    end
  end

  // ---------------- window address setup ----------------
  assign half_kw    = krn_width_r >> 1;
  assign half_kh    = krn_height_r >> 1;
  assign base_row   = signed'({2'b00, row_r}) - signed'({5'b00000, half_kh});
  assign width_s    = signed'({1'b0, img_width_r});
  assign row_prod   = base_row * width_s;
  assign start_addr = row_prod + signed'(ADDR_W'(col_r)) - signed'(ADDR_W'(half_kw));
  assign size_nxt   = (2*DIM_W)'(img_width_r) * (2*DIM_W)'(img_height_r);
  assign width_a    = signed'(ADDR_W'(img_width_r));

  assign last_kx = (kx_r == krn_width_r - KDIM_W'(1));
  assign last_ky = (ky_r == krn_height_r - KDIM_W'(1));
  assign no_taps = (krn_width_r == '0) || (krn_height_r == '0);

  // one tap per cycle, wrapping into the next kernel row
  always_ff @(posedge clk) begin
    if (compute_acc) begin
      col_r <= in_column;
      row_r <= in_row;
    end
    if (state_r == ST_SETUP) begin
      row_addr_r <= start_addr;
      addr_r     <= start_addr;
      size_r     <= size_nxt;
      kx_r       <= '0;
      ky_r       <= '0;
      widx_r     <= '0;
    end else if (tap_issue) begin
      widx_r <= widx_r + TAP_W'(1);
      if (last_kx) begin
        kx_r       <= '0;
        ky_r       <= ky_r + KDIM_W'(1);
        row_addr_r <= row_addr_r + width_a;
        addr_r     <= row_addr_r + width_a;
      end else begin
        kx_r   <= kx_r + KDIM_W'(1);
        addr_r <= addr_r + ADDR_W'(1);
      end
    end
    tap_zero_r <= !(pix_ok && wgt_ok);
  end

  // ---------------- sequencer ----------------
  assign pipe_busy = tap_vld_r || mac_busy;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == ST_DRAIN) && !pipe_busy && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (compute_acc) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = no_taps ? ST_DRAIN : ST_RUN;
      ST_RUN:   if (last_kx && last_ky) state_nxt = ST_DRAIN;
      ST_DRAIN: if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tap_vld_r <= tap_issue;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= mac_acc;
    end
  end

  // ---------------- shared multiply-accumulate ----------------
  always_comb begin
    mac_ctl.clear = compute_acc;
    mac_ctl.valid = tap_vld_r;
    mac_ctl.zero  = tap_zero_r;
  end

  imgconv_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .pixel  (pix_q_r),
    .weight (wgt_q_r),
    .acc    (mac_acc),
    .busy   (mac_busy)
  );

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;

  // ---------------- assertions ----------------
  a_compute_starts_setup: assert property (@(posedge clk) disable iff (!rst_n)
    compute_acc |=> (state_r == ST_SETUP))
    else $error("compute word did not start address setup");

  a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DRAIN))
    else $error("result word raised outside the drain phase");

  a_tap_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    tap_vld_r |-> $past(state_r == ST_RUN))
    else $error("tap data present without a tap issued");

  a_widx_in_kernel: assert property (@(posedge clk) disable iff (!rst_n)
    tap_issue |-> (widx_r < TAP_W'(krn_width_r) * TAP_W'(krn_height_r)))
    else $error("weight index beyond kernel size");

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> !in_acc)
    else $error("input word taken while taps are running");

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2d convolution image filter. The weight store
// and the low part of the image store are filled first, and image sizes keep
// every window inside the filled part. After directed words, random words run
// through several image and kernel sizes with random gaps and stalls on both
// channels. A scoreboard predicts each window sum and checks result words.
// ----------------------------------------------------------------------------

class window_sum_board;
  int img_w;
  int img_h;
  int ker_w;
  int ker_h;
  imgconv_pkg::sample_t pixels  [imgconv_pkg::MAX_PIXELS_DEF];
  imgconv_pkg::sample_t weights [imgconv_pkg::MAX_KERNEL_TAPS_DEF];
  imgconv_pkg::sample_t pending_sums [$];
  int faults;

  function new();
    img_w  = 64;
    img_h  = 64;
    ker_w  = 3;
    ker_h  = 3;
    faults = 0;
  endfunction

  function void set_reg(imgconv_pkg::cfg_index_t idx, int val);
    case (idx)
      imgconv_pkg::CFG_IMAGE_WIDTH:   img_w = val & 'h7f;
      imgconv_pkg::CFG_IMAGE_HEIGHT:  img_h = val & 'h7f;
      imgconv_pkg::CFG_KERNEL_WIDTH:  ker_w = val & 'h7;
      imgconv_pkg::CFG_KERNEL_HEIGHT: ker_h = val & 'h7;
      default: ;
    endcase
  endfunction

  function imgconv_pkg::sample_t filtered_at(int col, int row);
    int acc;
    int span;
    int addr;
    int tap;
    int pix;
    int wt;
    acc  = 0;
    span = img_w * img_h;
    for (int ky = 0; ky < ker_h; ky++) begin
      for (int kx = 0; kx < ker_w; kx++) begin
        addr = (row - ker_h / 2 + ky) * img_w + col - ker_w / 2 + kx;
        tap  = ky * ker_w + kx;
        // taps off the image or past the store read as zero
        pix  = (addr >= 0 && addr < span && addr < imgconv_pkg::MAX_PIXELS_DEF) ?
               int'(pixels[addr]) : 0;
        wt   = (tap < imgconv_pkg::MAX_KERNEL_TAPS_DEF) ? int'(weights[tap]) : 0;
        acc += pix * wt;
      end
    end
    return imgconv_pkg::sample_t'(acc);
  endfunction

  function void note_word(imgconv_pkg::opcode_t op, int slot, imgconv_pkg::sample_t val,
                          int col, int row);
    case (op)
      imgconv_pkg::OP_WRITE_PIXEL: begin
        if (slot < imgconv_pkg::MAX_PIXELS_DEF) pixels[slot] = val;
      end
      imgconv_pkg::OP_WRITE_WEIGHT: begin
        if (slot < imgconv_pkg::MAX_KERNEL_TAPS_DEF) weights[slot] = val;
      end
      imgconv_pkg::OP_COMPUTE: pending_sums.push_back(filtered_at(col, row));
      default: ;
    endcase
  endfunction

  function void check_filtered(imgconv_pkg::sample_t got);
    imgconv_pkg::sample_t want;
    if (pending_sums.size() == 0) begin
      faults++;
      if (faults <= 10) $display("unexpected result word: got %0d", got);
    end else begin
      want = pending_sums.pop_front();
      if (got !== want) begin
        faults++;
        if (faults <= 10)
          $display("filtered_value mismatch: expected %0d got %0d", want, got);
      end
    end
  endfunction
endclass

module tb_top;
  import imgconv_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 60;    // longer than one 7x7 window plus drain
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 30;
  localparam int FILL_PIXELS = 512;   // image sizes never span more than this
  localparam opcode_t OP_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  opcode_t               in_opcode;
  logic [SLOT_W-1:0]     in_slot;
  sample_t               in_sample_value;
  logic [POS_W-1:0]      in_column;
  logic [POS_W-1:0]      in_row;
  logic                  out_valid;
  logic                  out_stall;
  sample_t               out_filtered_value;
  logic                  cfg_we;
  cfg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  window_sum_board board;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_left  = 0;
  bit hold_req   = 1'b0;
  bit hold_taken = 1'b0;
  int cycles     = 0;

  image_conv2d_filter DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_slot            (in_slot),
    .in_sample_value    (in_sample_value),
    .in_column          (in_column),
    .in_row             (in_row),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_filtered_value (out_filtered_value),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when asked for
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_filtered(out_filtered_value);
  end

  function automatic sample_t any_sample();
    case ($urandom_range(0, 15))
      0: return sample_t'(16'h8000);
      1: return sample_t'(16'h7fff);
      2: return sample_t'(16'h0000);
      3: return sample_t'(16'hffff);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_word(opcode_t op, int slot, sample_t val, int col, int row);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_slot         <= slot[SLOT_W-1:0];
    in_sample_value <= val;
    in_column       <= col[POS_W-1:0];
    in_row          <= row[POS_W-1:0];
    do @(posedge clk); while (in_stall);
    board.note_word(op, slot, val, col, row);
  endtask

  task automatic put_reg(cfg_index_t idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic set_sizes(int w, int h, int kw, int kh);
    put_reg(CFG_IMAGE_WIDTH, w);
    put_reg(CFG_IMAGE_HEIGHT, h);
    put_reg(CFG_KERNEL_WIDTH, kw);
    put_reg(CFG_KERNEL_HEIGHT, kh);
    cfg_we <= 1'b0;
  endtask

  // block idle: every sum back, trailing writes given time to land
  task automatic settle();
    while (board.pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_random(int count);
    int done;
    int pick;
    int span;
    int slot;
    int col;
    int row;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      span = board.img_w * board.img_h;
      col  = $urandom_range(0, 63);
      row  = $urandom_range(0, 63);
      if (pick < 40) begin
        // mostly ask for positions inside the image
        if ($urandom_range(0, 1) && board.img_w > 0 && board.img_h > 0) begin
          col = $urandom_range(0, (board.img_w > 64 ? 64 : board.img_w) - 1);
          row = $urandom_range(0, (board.img_h > 64 ? 64 : board.img_h) - 1);
        end
        send_word(OP_COMPUTE, $urandom_range(0, 4095), any_sample(), col, row);
        done++;
      end else if (pick < 75) begin
        if ($urandom_range(0, 1) && span >= 1 && span <= MAX_PIXELS_DEF)
          slot = $urandom_range(0, span - 1);
        else
          slot = $urandom_range(0, MAX_PIXELS_DEF - 1);
        send_word(OP_WRITE_PIXEL, slot, any_sample(), col, row);
        done++;
      end else if (pick < 93) begin
        if ($urandom_range(0, 9) == 0)
          slot = $urandom_range(MAX_KERNEL_TAPS_DEF, 4095);
        else
          slot = $urandom_range(0, MAX_KERNEL_TAPS_DEF - 1);
        send_word(OP_WRITE_WEIGHT, slot, any_sample(), col, row);
        done++;
      end else begin
        send_word(OP_SPARE, $urandom_range(0, 4095), any_sample(), col, row);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int ph_w     [PHASES] = '{64, 1, 0, 127, 37, 1, 64, 3};
    int ph_h     [PHASES] = '{8, 1, 64, 4, 13, 1, 1, 0};
    int ph_kw    [PHASES] = '{7, 1, 0, 7, 5, 1, 2, 3};
    int ph_kh    [PHASES] = '{7, 1, 3, 1, 4, 1, 7, 7};
    int ph_idle  [PHASES] = '{0, 58, 0, 29, 0, 58, 0, 29};
    int ph_stall [PHASES] = '{0, 0, 58, 29, 0, 0, 58, 29};
    int rw;
    int rh;
    board = new();
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_opcode       <= OP_WRITE_PIXEL;
    in_slot         <= '0;
    in_sample_value <= '0;
    in_column       <= '0;
    in_row          <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_IMAGE_WIDTH;
    cfg_data        <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // keep windows inside the part of the image store filled below
    set_sizes(64, FILL_PIXELS / 64, 3, 3);

    // fill the weights and the low pixels so no window reads an unwritten entry
    for (int i = 0; i < MAX_KERNEL_TAPS_DEF; i++)
      send_word(OP_WRITE_WEIGHT, i, any_sample(), $urandom_range(0, 63), $urandom_range(0, 63));
    for (int i = 0; i < FILL_PIXELS; i++)
      send_word(OP_WRITE_PIXEL, i, any_sample(), $urandom_range(0, 63), $urandom_range(0, 63));

    // directed words on a 64x8 image with a 3x3 kernel
    send_word(OP_WRITE_WEIGHT, 0, sample_t'(16'h8000), 0, 0);
    send_word(OP_WRITE_WEIGHT, 8, sample_t'(16'h7fff), 63, 63);
    send_word(OP_WRITE_WEIGHT, 49, sample_t'(16'h1234), 0, 0);    // past the weight store
    send_word(OP_WRITE_WEIGHT, 4095, sample_t'(16'hffff), 63, 63);
    send_word(OP_SPARE, 4095, sample_t'(16'hffff), 63, 63);
    send_word(OP_WRITE_PIXEL, 0, sample_t'(16'h7fff), 0, 0);
    send_word(OP_WRITE_PIXEL, 4095, sample_t'(16'h8000), 63, 63);
    send_word(OP_WRITE_PIXEL, 65, sample_t'(16'h8000), 0, 0);
    send_word(OP_COMPUTE, 0, sample_t'(16'h0000), 0, 0);           // taps above and left
    send_word(OP_COMPUTE, 4095, sample_t'(16'hffff), 63, 63);      // taps below the image
    send_word(OP_COMPUTE, 0, sample_t'(16'h0000), 63, 0);          // wraps into next row
    send_word(OP_COMPUTE, 0, sample_t'(16'h0000), 0, 1);           // wraps into row above
    send_word(OP_COMPUTE, 0, sample_t'(16'h0000), 1, 1);
    send_word(OP_WRITE_PIXEL, 64, sample_t'(16'h7fff), 0, 0);
    send_word(OP_COMPUTE, 0, sample_t'(16'h0000), 0, 1);
    send_word(OP_COMPUTE, 0, sample_t'(16'h0000), 31, 32);
    in_valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 5) begin
        rw = $urandom_range(1, 64);
        rh = $urandom_range(1, (FILL_PIXELS / rw > 64) ? 64 : FILL_PIXELS / rw);
        set_sizes(rw, rh, $urandom_range(1, 7), $urandom_range(1, 7));
      end else begin
        set_sizes(ph_w[p], ph_h[p], ph_kw[p], ph_kh[p]);
      end
      idle_pct  = ph_idle[p];
      stall_pct = ph_stall[p];
      // receiver holds off while the sender keeps going, so the block backs up
      if (p == 4) hold_req = 1'b1;
      run_random(PHASE_WORDS);
    end

    settle();
    if (board.faults == 0 && board.pending_sums.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
